FILE: sv/uerh_pkg.sv
package uerh_pkg;

    // History store depth and derived widths
    localparam int HIST_DEPTH = 5;
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    // Field widths
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int STAMP_W  = 32;
    localparam int PULSE_W  = 20;
    localparam int TRIG_W   = 8;
    localparam int DIV_W    = 8;
    localparam int STEP_W   = $clog2(PULSE_W);

    localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUMP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DATA     = 3'd5;

    // Measurement phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    // Register map (word index)
    localparam logic [1:0] REG_TRIGGER = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DIVISOR = 2'd2;

    localparam logic [TRIG_W-1:0]  TRIGGER_RESET = 8'd10;
    localparam logic [PULSE_W-1:0] TIMEOUT_RESET = 20'd1000000;
    localparam logic [DIV_W-1:0]   DIVISOR_RESET = 8'd58;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [PULSE_W-1:0] pulse;
        logic [PULSE_W-1:0] distance;
    } hist_entry_t;

endpackage

FILE: sv/ultrasonic_echo_ranger_history_unit.sv
// Ultrasonic echo ranger with a newest-first reading history. Items arrive on the s_ stream
// (tuser = kind: tick, start, read latest, dump, clear) and one result per item leaves on
// the m_ stream, five for a dump (tlast marks the final one). Kinds 5 to 7 give no result.
// One item is worked on at a time. Most items pass S_IDLE, which takes the transfer, then
// S_EXEC, which forms the result. A tick that ends a reading goes on through S_DIV: the
// distance comes from a restoring divider that retires one quotient bit per cycle over the
// 20-bit pulse width, then S_REC stores and reports the reading. Each dump entry costs
// one registered read of the history RAM in S_DRD, then S_DOUT places it. The result
// register decouples the two sides: a new item is taken while a result still waits on
// m_tready. Registers on the APB-style port: 0x0 trigger ticks, 0x4 timeout ticks,
// 0x8 distance divisor; write them only while the block is idle.
module ultrasonic_echo_ranger_history_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [0] echo_level, [32:1] now_seconds, [39:33] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [0] trigger_level, [32:1] stamp_seconds,
                                   // [52:33] pulse_us, [72:53] distance_cm,
                                   // [73] entry_valid, [79:74] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,   // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // take a transfer
    localparam logic [2:0] S_EXEC = 3'd1;  // form the result of the held item
    localparam logic [2:0] S_DIV  = 3'd2;  // one quotient bit per cycle
    localparam logic [2:0] S_REC  = 3'd3;  // store the reading and report it
    localparam logic [2:0] S_DRD  = 3'd4;  // read one history entry
    localparam logic [2:0] S_DOUT = 3'd5;  // report that entry

    logic [2:0] state_reg, state_next;

    // held input item
    logic [uerh_pkg::KIND_W-1:0]  in_kind_reg;
    logic                         in_echo_reg;
    logic [uerh_pkg::STAMP_W-1:0] in_now_reg;

    // configuration
    logic [uerh_pkg::TRIG_W-1:0]  trig_ticks_reg;
    logic [uerh_pkg::PULSE_W-1:0] timeout_reg;
    logic [uerh_pkg::DIV_W-1:0]   divisor_reg;

    // measurement state
    logic [1:0]                   phase_reg, phase_next;
    logic [uerh_pkg::PULSE_W-1:0] cnt_reg, cnt_next;
    logic                         pending_reg, pending_next;
    logic [uerh_pkg::STAMP_W-1:0] lat_stamp_reg, lat_stamp_next;
    logic [uerh_pkg::PULSE_W-1:0] lat_pulse_reg, lat_pulse_next;
    logic [uerh_pkg::PULSE_W-1:0] lat_dist_reg, lat_dist_next;

    // history ring bookkeeping: head points at the newest entry
    logic [uerh_pkg::IDX_W-1:0]   head_reg, head_next;
    logic [uerh_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [uerh_pkg::IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [uerh_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [uerh_pkg::IDX_W-1:0]   head_inc;
    logic [uerh_pkg::IDX_W-1:0]   rd_ptr_dec;

    // divider
    logic [uerh_pkg::PULSE_W-1:0] pulse_w_reg, pulse_w_next;
    logic [uerh_pkg::PULSE_W-1:0] quo_reg, quo_next;
    logic [uerh_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [uerh_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [uerh_pkg::DIV_W:0]     div_trial;
    logic [uerh_pkg::DIV_W:0]     div_diff;
    logic                         div_ge;

    // history RAM
    uerh_pkg::hist_entry_t        mem [uerh_pkg::HIST_DEPTH];
    uerh_pkg::hist_entry_t        rdata_reg;
    uerh_pkg::hist_entry_t        mem_wdata;
    logic                         mem_we;
    logic                         mem_re;
    logic [uerh_pkg::IDX_W-1:0]   mem_waddr;

    // result register
    logic                          m_valid_reg;
    logic                          m_trig_reg;
    logic [uerh_pkg::STATUS_W-1:0] m_status_reg;
    logic [uerh_pkg::STAMP_W-1:0]  m_stamp_reg;
    logic [uerh_pkg::PULSE_W-1:0]  m_pulse_reg;
    logic [uerh_pkg::PULSE_W-1:0]  m_dist_reg;
    logic                          m_entry_valid_reg;
    logic                          m_last_reg;

    logic                          emit;
    logic                          e_trig;
    logic [uerh_pkg::STATUS_W-1:0] e_status;
    logic [uerh_pkg::STAMP_W-1:0]  e_stamp;
    logic [uerh_pkg::PULSE_W-1:0]  e_pulse;
    logic [uerh_pkg::PULSE_W-1:0]  e_dist;
    logic                          e_entry_valid;
    logic                          e_last;

    logic                          slot_free;
    logic [uerh_pkg::PULSE_W-1:0]  cnt_inc;
    logic                          cfg_wr;
    logic                          dump_valid;

    assign s_tready  = (state_reg == S_IDLE);
    assign slot_free = !m_valid_reg || m_tready;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    assign head_inc   = (head_reg == uerh_pkg::IDX_W'(uerh_pkg::HIST_DEPTH - 1)) ?
                        '0 : head_reg + 1'b1;
    assign rd_ptr_dec = (rd_ptr_reg == '0) ?
                        uerh_pkg::IDX_W'(uerh_pkg::HIST_DEPTH - 1) : rd_ptr_reg - 1'b1;

    // restoring division step: shift in the next dividend bit, subtract when it fits
    assign div_trial = {rem_reg, quo_reg[uerh_pkg::PULSE_W-1]};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});
    assign div_diff  = div_trial - {1'b0, divisor_reg};

    assign dump_valid = (k_reg < count_reg);

    // configuration read back
    always_comb
    begin
        case (paddr[3:2])
            uerh_pkg::REG_TRIGGER: prdata = {24'd0, trig_ticks_reg};
            uerh_pkg::REG_TIMEOUT: prdata = {12'd0, timeout_reg};
            uerh_pkg::REG_DIVISOR: prdata = {24'd0, divisor_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        pending_next   = pending_reg;
        lat_stamp_next = lat_stamp_reg;
        lat_pulse_next = lat_pulse_reg;
        lat_dist_next  = lat_dist_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        k_next         = k_reg;
        pulse_w_next   = pulse_w_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = head_inc;
        mem_wdata = '0;

        emit          = 1'b0;
        e_trig        = 1'b0;
        e_status      = uerh_pkg::ST_IDLE;
        e_stamp       = '0;
        e_pulse       = '0;
        e_dist        = '0;
        e_entry_valid = 1'b0;
        e_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // hold until the result register can take a result
                if (slot_free)
                begin
                    state_next = S_IDLE;
                    case (in_kind_reg)
                        uerh_pkg::KIND_TICK:
                        begin
                            emit     = 1'b1;
                            e_status = uerh_pkg::ST_BUSY;
                            case (phase_reg)
                                uerh_pkg::PH_TRIG:
                                begin
                                    e_trig   = 1'b1;
                                    cnt_next = cnt_inc;
                                    // a zero length compares as one tick
                                    if (cnt_inc >= uerh_pkg::PULSE_W'(trig_ticks_reg))
                                    begin
                                        phase_next = uerh_pkg::PH_RISE;
                                        cnt_next   = '0;
                                    end
                                end
                                uerh_pkg::PH_RISE:
                                begin
                                    if (in_echo_reg)
                                    begin
                                        phase_next = uerh_pkg::PH_HIGH;
                                        cnt_next   = uerh_pkg::PULSE_W'(1);
                                    end
                                    else if (cnt_inc >= timeout_reg)
                                    begin
                                        phase_next = uerh_pkg::PH_IDLE;
                                        cnt_next   = '0;
                                        e_status   = uerh_pkg::ST_TIMEOUT;
                                    end
                                    else
                                    begin
                                        cnt_next = cnt_inc;
                                    end
                                end
                                uerh_pkg::PH_HIGH:
                                begin
                                    if (!in_echo_reg)
                                    begin
                                        // falling edge: divide, then record
                                        emit         = 1'b0;
                                        phase_next   = uerh_pkg::PH_IDLE;
                                        cnt_next     = '0;
                                        pulse_w_next = cnt_reg;
                                        quo_next     = cnt_reg;
                                        rem_next     = '0;
                                        step_next    = '0;
                                        state_next   = S_DIV;
                                    end
                                    else if (cnt_reg >= timeout_reg)
                                    begin
                                        phase_next = uerh_pkg::PH_IDLE;
                                        cnt_next   = '0;
                                        e_status   = uerh_pkg::ST_TIMEOUT;
                                    end
                                    else
                                    begin
                                        cnt_next = cnt_inc;
                                    end
                                end
                                default:
                                begin
                                    e_status = uerh_pkg::ST_IDLE;
                                end
                            endcase
                        end

                        uerh_pkg::KIND_START:
                        begin
                            emit = 1'b1;
                            if (pending_reg)
                            begin
                                e_status = uerh_pkg::ST_REJECTED;
                                e_trig   = (phase_reg == uerh_pkg::PH_TRIG);
                            end
                            else
                            begin
                                pending_next = 1'b1;
                                phase_next   = uerh_pkg::PH_TRIG;
                                cnt_next     = '0;
                                e_status     = uerh_pkg::ST_BUSY;
                                e_trig       = 1'b1;
                            end
                        end

                        uerh_pkg::KIND_READ:
                        begin
                            emit         = 1'b1;
                            pending_next = 1'b0;
                            e_status     = uerh_pkg::ST_DATA;
                            e_trig       = (phase_reg == uerh_pkg::PH_TRIG);
                            e_stamp      = lat_stamp_reg;
                            e_pulse      = lat_pulse_reg;
                            e_dist       = lat_dist_reg;
                        end

                        uerh_pkg::KIND_DUMP:
                        begin
                            k_next      = '0;
                            rd_ptr_next = head_reg;
                            state_next  = S_DRD;
                        end

                        uerh_pkg::KIND_CLEAR:
                        begin
                            emit         = 1'b1;
                            pending_next = 1'b0;
                            phase_next   = uerh_pkg::PH_IDLE;
                            cnt_next     = '0;
                            count_next   = '0;
                        end

                        default:
                        begin
                            // unused kinds: drop silently
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                quo_next  = {quo_reg[uerh_pkg::PULSE_W-2:0], div_ge};
                rem_next  = div_ge ? div_diff[uerh_pkg::DIV_W-1:0] :
                                     div_trial[uerh_pkg::DIV_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == uerh_pkg::STEP_W'(uerh_pkg::PULSE_W - 1))
                begin
                    state_next = S_REC;
                end
            end

            S_REC:
            begin
                if (slot_free)
                begin
                    lat_stamp_next = in_now_reg;
                    lat_pulse_next = pulse_w_reg;
                    lat_dist_next  = (divisor_reg == '0) ? uerh_pkg::PULSE_MAX : quo_reg;

                    // push the newest reading; a full ring overwrites the oldest
                    mem_we             = 1'b1;
                    mem_waddr          = head_inc;
                    mem_wdata.stamp    = lat_stamp_next;
                    mem_wdata.pulse    = lat_pulse_next;
                    mem_wdata.distance = lat_dist_next;
                    head_next          = head_inc;
                    if (count_reg < uerh_pkg::CNT_W'(uerh_pkg::HIST_DEPTH))
                    begin
                        count_next = count_reg + 1'b1;
                    end

                    emit       = 1'b1;
                    e_status   = uerh_pkg::ST_DONE;
                    e_stamp    = lat_stamp_next;
                    e_pulse    = lat_pulse_next;
                    e_dist     = lat_dist_next;
                    state_next = S_IDLE;
                end
            end

            S_DRD:
            begin
                mem_re     = 1'b1;
                state_next = S_DOUT;
            end

            S_DOUT:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    e_status      = uerh_pkg::ST_DATA;
                    e_trig        = (phase_reg == uerh_pkg::PH_TRIG);
                    e_entry_valid = dump_valid;
                    e_stamp       = dump_valid ? rdata_reg.stamp    : '0;
                    e_pulse       = dump_valid ? rdata_reg.pulse    : '0;
                    e_dist        = dump_valid ? rdata_reg.distance : '0;
                    e_last        = (k_reg == uerh_pkg::CNT_W'(uerh_pkg::HIST_DEPTH - 1));
                    rd_ptr_next   = rd_ptr_dec;
                    k_next        = k_reg + 1'b1;
                    if (e_last)
                    begin
                        // a dump empties the history
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= uerh_pkg::PH_IDLE;
            cnt_reg        <= '0;
            pending_reg    <= 1'b0;
            lat_stamp_reg  <= '0;
            lat_pulse_reg  <= '0;
            lat_dist_reg   <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            trig_ticks_reg <= uerh_pkg::TRIGGER_RESET;
            timeout_reg    <= uerh_pkg::TIMEOUT_RESET;
            divisor_reg    <= uerh_pkg::DIVISOR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            pending_reg   <= pending_next;
            lat_stamp_reg <= lat_stamp_next;
            lat_pulse_reg <= lat_pulse_next;
            lat_dist_reg  <= lat_dist_next;
            head_reg      <= head_next;
            count_reg     <= count_next;

            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                case (paddr[3:2])
                    uerh_pkg::REG_TRIGGER: trig_ticks_reg <= pwdata[uerh_pkg::TRIG_W-1:0];
                    uerh_pkg::REG_TIMEOUT: timeout_reg    <= pwdata[uerh_pkg::PULSE_W-1:0];
                    uerh_pkg::REG_DIVISOR: divisor_reg    <= pwdata[uerh_pkg::DIV_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_echo_reg <= s_tdata[0];
            in_now_reg  <= s_tdata[32:1];
        end

        rd_ptr_reg  <= rd_ptr_next;
        k_reg       <= k_next;
        pulse_w_reg <= pulse_w_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;

        if (emit)
        begin
            m_trig_reg        <= e_trig;
            m_status_reg      <= e_status;
            m_stamp_reg       <= e_stamp;
            m_pulse_reg       <= e_pulse;
            m_dist_reg        <= e_dist;
            m_entry_valid_reg <= e_entry_valid;
            m_last_reg        <= e_last;
        end
    end

    // history RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_entry_valid_reg, m_dist_reg, m_pulse_reg,
                       m_stamp_reg, m_trig_reg};

endmodule
